// ===== rtl/assert_macros.svh =====
// Assertion helpers, included by the assembler core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property checked on every rising edge, suspended while reset is low.
`define ASSERT_RST(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Property checked on every rising edge with no reset qualification.
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`else

`define ASSERT_RST(label, clk, rst_n, prop)
`define ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

// ===== rtl/stqa_pkg.sv =====
package stqa_pkg;

    // Fixed width of the index fields on the ports.
    localparam int IDX_W = 32;

    // Command codes of an input word.
    localparam logic [1:0] CMD_STRIP = 2'd0;
    localparam logic [1:0] CMD_LIST  = 2'd1;
    localparam logic [1:0] CMD_BEGIN = 2'd2;

    // Segment position at which the next strip vertex closes a quad.
    localparam logic [1:0] POS_QUAD  = 2'd3;
    localparam logic [1:0] POS_AFTER = 2'd2;
    localparam logic [1:0] POS_START = 2'd0;

    // Number of words in one quad, and so of output cells.
    localparam int QUAD_SIZE = 4;
    localparam int WIN_SIZE  = 3;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [IDX_W-1:0] index_value;
        logic             restart_allowed;
    } t_in_word;

    typedef struct packed {
        logic [IDX_W-1:0] index_out;
        logic             group_last;
    } t_out_word;

    // Control of one output cell.
    typedef struct packed {
        logic load;
        logic shift;
    } t_out_ctl;

    // Contents of one output cell.
    typedef struct packed {
        logic      valid;
        t_out_word word;
    } t_out_slot;

endpackage

// ===== rtl/strip_to_quad_index_assembler_core.sv =====
// Channel   | valid        | stall        | word
// ----------+--------------+--------------+-------------
// input     | i_in_valid   | o_in_stall   | i_in_word
// output    | o_out_valid  | i_out_stall  | o_out_word
// config    | i_cfg_we     | (none)       | i_cfg_wdata
//
// An input word is taken whenever it is valid and not stalled; a quad leaves one word at a time
// and a list vertex as a single word, both from a four-cell output chain whose head is the output register.
// Steady strip throughput is bounded by the one-word output port.
// A word that produces results stalls until the output chain holds at most its head word and that word leaves.
// Reset (synchronous, active low) clears the chain, segment state and configuration.
module strip_to_quad_index_assembler_core #(
    parameter int INDEX_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_wdata,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  stqa_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output stqa_pkg::t_out_word o_out_word
);
    import stqa_pkg::*;

    `include "assert_macros.svh"

    logic                  r_glob;
    logic                  r_op_en;
    logic [INDEX_BITS-1:0] r_op_val;
    logic [1:0]            r_pos;
    logic [1:0]            n_pos;

    logic [INDEX_BITS-1:0] vtx;
    logic                  in_acc;
    logic                  is_strip;
    logic                  is_list;
    logic                  is_restart;
    logic                  emit_quad;
    logic                  need_out;
    logic                  head_free;
    logic                  chain_free;
    logic                  win_shift;
    logic                  quad_acc;
    logic                  chain_packed;

    logic [INDEX_BITS-1:0] win_q [WIN_SIZE];
    t_out_slot             slot  [QUAD_SIZE];
    t_out_slot             nxt   [QUAD_SIZE];
    t_out_ctl              ctl   [QUAD_SIZE];
    t_out_word             ld    [QUAD_SIZE];

    // Decode of the incoming word against the segment state.
    assign vtx        = i_in_word.index_value[INDEX_BITS-1:0];
    assign is_strip   = (i_in_word.cmd == CMD_STRIP);
    assign is_list    = (i_in_word.cmd == CMD_LIST);
    assign is_restart = is_strip && r_glob && r_op_en && (vtx == r_op_val);
    assign emit_quad  = is_strip && !is_restart && (r_pos == POS_QUAD);
    assign need_out   = is_list || emit_quad;

    // The chain is free when at most the head holds a word and it leaves now.
    assign head_free  = !slot[0].valid || !i_out_stall;
    assign chain_free = !slot[1].valid && head_free;
    assign o_in_stall = need_out && !chain_free;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign win_shift  = in_acc && is_strip && !is_restart;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_glob <= 1'b0;
        end else if (i_cfg_we) begin
            r_glob <= i_cfg_wdata;
        end
    end

    // Next segment position.
    always_comb begin
        n_pos = r_pos;
        case (i_in_word.cmd)
            CMD_BEGIN: begin
                n_pos = POS_START;
            end
            CMD_STRIP: begin
                if (is_restart) begin
                    n_pos = POS_START;
                end else if (r_pos == POS_QUAD) begin
                    n_pos = POS_AFTER;
                end else begin
                    n_pos = r_pos + 2'd1;
                end
            end
            default: begin
                n_pos = r_pos;
            end
        endcase
    end

    // Operation and segment state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= POS_START;
            r_op_en  <= 1'b0;
            r_op_val <= '0;
        end else if (in_acc) begin
            r_pos <= n_pos;
            if (i_in_word.cmd == CMD_BEGIN) begin
                r_op_en  <= i_in_word.restart_allowed;
                r_op_val <= vtx;
            end
        end
    end

    // Window chain: the newest vertex enters at the top cell, the oldest sits at cell 0.
    for (genvar g = 0; g < WIN_SIZE; g++) begin : g_win
        logic [INDEX_BITS-1:0] win_d;
        if (g == WIN_SIZE - 1) begin : g_top
            assign win_d = vtx;
        end else begin : g_mid
            assign win_d = win_q[g+1];
        end
        stqa_win_cell #(
            .W (INDEX_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_shift (win_shift),
            .i_data  (win_d),
            .o_data  (win_q[g])
        );
    end

    // Output chain: quads load in parallel, words shift toward the head cell.
    for (genvar g = 0; g < QUAD_SIZE; g++) begin : g_out
        if (g == QUAD_SIZE - 1) begin : g_tail
            assign nxt[g] = '0;
            assign ld[g]  = '{index_out: IDX_W'(vtx), group_last: 1'b1};
        end else begin : g_body
            assign nxt[g] = slot[g+1];
            if (g == 0) begin : g_head
                assign ld[g] = emit_quad
                             ? t_out_word'{index_out: IDX_W'(win_q[g]), group_last: 1'b0}
                             : t_out_word'{index_out: IDX_W'(vtx), group_last: 1'b1};
            end else begin : g_inner
                assign ld[g] = '{index_out: IDX_W'(win_q[g]), group_last: 1'b0};
            end
        end
        assign ctl[g].load  = in_acc && need_out && ((g == 0) || emit_quad);
        assign ctl[g].shift = head_free;
        stqa_out_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (ctl[g]),
            .i_load_word (ld[g]),
            .i_next      (nxt[g]),
            .o_slot      (slot[g])
        );
    end

    assign o_out_valid = slot[0].valid;
    assign o_out_word  = slot[0].word;

    // Terms shared by the checks below.
    assign quad_acc     = in_acc && emit_quad;
    assign chain_packed = (!slot[1].valid || slot[0].valid)
                       && (!slot[2].valid || slot[1].valid)
                       && (!slot[3].valid || slot[2].valid);

    // Occupied output cells always form an unbroken run from the head.
    `ASSERT_RST(a_chain_packed, i_clk, i_rst_n, chain_packed)
    // A taken quad shows its first word, not a closing one, in the next cycle.
    `ASSERT_RST(a_quad_head, i_clk, i_rst_n, quad_acc |=> (o_out_valid && !o_out_word.group_last))
    // A restart vertex always starts a new segment.
    `ASSERT_RST(a_restart_pos, i_clk, i_rst_n, (in_acc && is_restart) |=> (r_pos == POS_START))
    // A quad closes only with the segment left one vertex short of the next quad.
    `ASSERT_RST(a_quad_pos, i_clk, i_rst_n, quad_acc |=> (r_pos == POS_AFTER))

endmodule

// ===== rtl/stqa_win_cell.sv =====
module stqa_win_cell #(
    parameter int W = 32
) (
    input  logic         i_clk,
    input  logic         i_shift,
    input  logic [W-1:0] i_data,
    output logic [W-1:0] o_data
);

    logic [W-1:0] r_data;

    // Take the vertex on i_data (the neighbor's, or the new vertex at the top cell) when the window slides.
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_data <= i_data;
        end
    end

    assign o_data = r_data;

endmodule

// ===== rtl/stqa_out_cell.sv =====
module stqa_out_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  stqa_pkg::t_out_ctl  i_ctl,
    input  stqa_pkg::t_out_word i_load_word,
    input  stqa_pkg::t_out_slot i_next,
    output stqa_pkg::t_out_slot o_slot
);
    import stqa_pkg::*;

    logic      r_valid;
    t_out_word r_word;

    // Valid bit: a parallel load wins over a shift from the neighbor.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.load) begin
            r_valid <= 1'b1;
        end else if (i_ctl.shift) begin
            r_valid <= i_next.valid;
        end
    end

    // Word payload follows the same selection.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_word <= i_load_word;
        end else if (i_ctl.shift) begin
            r_word <= i_next.word;
        end
    end

    assign o_slot.valid = r_valid;
    assign o_slot.word  = r_word;

endmodule
